FILE: src/kf800_pkg.sv
// Shared types, constants and functions for the Keccak-f[800] variant block.
// No dependencies; imported by kf800_ctrl, kf800_dp, the top level, the checker and the testbench.
package kf800_pkg;

    localparam int LANES       = 25;
    localparam int LANE_W      = 32;
    localparam int IDX_W       = 5;
    localparam int ROUND_COUNT = 22;

    localparam logic [IDX_W-1:0] LAST_LANE  = IDX_W'(LANES - 1);
    localparam logic [IDX_W-1:0] LAST_ROUND = IDX_W'(ROUND_COUNT - 1);

    typedef logic [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic             load;
        logic             shift;
        logic             round;
        logic [IDX_W-1:0] rnd_idx;
    } t_dp_cmd;

    function automatic t_lane round_const(input logic [IDX_W-1:0] idx);
        t_lane rc;
        case (idx)
            5'd0:    rc = 32'h0000_0001;
            5'd1:    rc = 32'h0000_8082;
            5'd2:    rc = 32'h0000_808a;
            5'd3:    rc = 32'h8000_8000;
            5'd4:    rc = 32'h0000_808b;
            5'd5:    rc = 32'h8000_0001;
            5'd6:    rc = 32'h8000_8081;
            5'd7:    rc = 32'h0000_8009;
            5'd8:    rc = 32'h0000_008a;
            5'd9:    rc = 32'h0000_0088;
            5'd10:   rc = 32'h8000_8009;
            5'd11:   rc = 32'h8000_000a;
            5'd12:   rc = 32'h8000_808b;
            5'd13:   rc = 32'h0000_008b;
            5'd14:   rc = 32'h0000_8089;
            5'd15:   rc = 32'h0000_8003;
            5'd16:   rc = 32'h0000_8002;
            5'd17:   rc = 32'h0000_0080;
            5'd18:   rc = 32'h0000_800a;
            5'd19:   rc = 32'h8000_000a;
            5'd20:   rc = 32'h8000_8081;
            5'd21:   rc = 32'h0000_8080;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    function automatic t_lane rotl(input t_lane x, input int n);
        int m;
        m = n % LANE_W;
        return (m == 0) ? x : t_lane'((x << m) | (x >> (LANE_W - m)));
    endfunction

    function automatic int rho_amount(input int k);
        return ((k * (k + 1)) / 2) % LANE_W;
    endfunction

endpackage

FILE: src/kf800_ctrl.sv
// Controller: load counter, round/emit counter and run state machine.
// Depends on kf800_pkg; drives commands into kf800_dp.
module kf800_ctrl import kf800_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_lane_index,
    output logic             o_last_lane,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {S_LOAD, S_ROUND, S_EMIT} t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_cnt      = r_cnt;
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    if (r_load_cnt >= LAST_LANE) begin
                        n_load_cnt = '0;
                        n_cnt      = '0;
                        n_state    = S_ROUND;
                    end else begin
                        n_load_cnt = r_load_cnt + 1'b1;
                    end
                end
            end
            S_ROUND: begin
                if (r_cnt == LAST_ROUND) begin
                    n_cnt   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_EMIT: begin
                if (r_cnt == LAST_LANE) begin
                    n_cnt   = '0;
                    n_state = S_LOAD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_cnt      <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_cnt      <= n_cnt;
        end
    end

    assign o_busy       = (r_state != S_LOAD);
    assign o_valid      = (r_state == S_EMIT);
    assign o_lane_index = r_cnt;
    assign o_last_lane  = (r_state == S_EMIT) && (r_cnt == LAST_LANE);

    assign o_cmd.load    = (r_state == S_LOAD) && i_start;
    assign o_cmd.shift   = ((r_state == S_LOAD) && i_start) || (r_state == S_EMIT);
    assign o_cmd.round   = (r_state == S_ROUND);
    assign o_cmd.rnd_idx = r_cnt;

endmodule

FILE: src/kf800_dp.sv
// Datapath: 25-lane state register, shift line for load/emit, one round per cycle.
// Depends on kf800_pkg; commanded by kf800_ctrl.
module kf800_dp import kf800_pkg::*; (
    input  logic    i_clk,
    input  t_dp_cmd i_cmd,
    input  t_lane   i_lane_in,
    output t_lane   o_lane_out
);

    t_lane r_s [LANES];
    t_lane n_rnd [LANES];

    always_comb begin
        t_lane c [5];
        t_lane d [5];
        t_lane t [LANES];
        t_lane p [LANES];
        for (int i = 0; i < 5; i++) begin
            c[i] = r_s[i] ^ r_s[i+5] ^ r_s[i+10] ^ r_s[i+15] ^ r_s[i+20];
        end
        for (int i = 0; i < 5; i++) begin
            d[i] = c[(i+4)%5] ^ rotl(c[(i+1)%5], 1);
        end
        for (int i = 0; i < LANES; i++) begin
            t[i] = r_s[i] ^ d[i%5];
        end
        p[0] = t[0];
        p[1] = rotl(t[1], 1);
        for (int k = 2; k < LANES; k++) begin
            p[k] = rotl(t[k-1], rho_amount(k));
        end
        for (int r = 0; r < LANES; r += 5) begin
            for (int i = 0; i < 5; i++) begin
                n_rnd[r+i] = p[r+i] ^ (~p[r+(i+1)%5] & p[r+(i+2)%5]);
            end
        end
        n_rnd[0] = n_rnd[0] ^ round_const(i_cmd.rnd_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.round) begin
            for (int i = 0; i < LANES; i++) begin
                r_s[i] <= n_rnd[i];
            end
        end else if (i_cmd.shift) begin
            for (int i = 0; i < LANES - 1; i++) begin
                r_s[i] <= r_s[i+1];
            end
            if (i_cmd.load) begin
                r_s[LANES-1] <= i_lane_in;
            end
        end
    end

    assign o_lane_out = r_s[0];

endmodule

FILE: src/keccak_f800_variant_permutation.sv
// Top level of the Keccak-f[800] variant permutation block.
// Depends on kf800_pkg, kf800_ctrl and kf800_dp.
//
// Usage:
//   Input: drive i_lane_in and raise i_start; an item is taken at each rising
//   edge where i_start is high and o_busy is low. Lanes arrive in order 0..24,
//   one item per lane.
//   After lane 24 is taken, o_busy rises for the run: 22 rounds
//   (one round per cycle in a single round unit), then 25 lanes of output.
//   Output: o_valid marks each result for exactly one cycle; lanes leave in
//   order 0..24 on consecutive cycles with o_lane_index, and o_last_lane is
//   high on lane 24. The first lane appears once the last round is done.
//   o_busy falls after the last lane; no new lane is taken during a run.
//   The receiver cannot stall; results must be taken when shown.
//   Reset (i_rst_n low, synchronous) returns the block to the loading state
//   with the lane count at zero; state lanes are not cleared, since all 25
//   are written before any is read.
module keccak_f800_variant_permutation import kf800_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [31:0]      i_lane_in,
    output logic             o_busy,
    output logic             o_valid,
    output logic [31:0]      o_lane_out,
    output logic [IDX_W-1:0] o_lane_index,
    output logic             o_last_lane
);

    t_dp_cmd cmd;

    kf800_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_lane_index (o_lane_index),
        .o_last_lane  (o_last_lane),
        .o_cmd        (cmd)
    );

    kf800_dp u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_lane_in  (i_lane_in),
        .o_lane_out (o_lane_out)
    );

endmodule

FILE: src/kf800_checker.sv
// Port-level checker for keccak_f800_variant_permutation, bound to the top level.
// Depends on kf800_pkg.
module kf800_checker import kf800_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             o_busy,
    input logic             o_valid,
    input logic [IDX_W-1:0] o_lane_index,
    input logic             o_last_lane
);

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("item shown while not busy");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_lane |-> o_lane_index == LAST_LANE)
        else $error("last item flag on wrong lane");

    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_lane |=>
            o_valid && (o_lane_index == $past(o_lane_index) + 1'b1))
        else $error("items not back to back in lane order");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_lane |=> !o_busy && !o_valid)
        else $error("busy after last item");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy without an accepted item");

endmodule

bind keccak_f800_variant_permutation kf800_checker u_kf800_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (i_start),
    .o_busy       (o_busy),
    .o_valid      (o_valid),
    .o_lane_index (o_lane_index),
    .o_last_lane  (o_last_lane)
);

FILE: dv/keccak_f800_variant_permutation_tb.sv
// Testbench for keccak_f800_variant_permutation: loads 25-lane states, predicts the
// permuted lanes with an independent round model and checks every emitted lane.
// Depends on kf800_pkg and the keccak_f800_variant_permutation RTL.
module keccak_f800_variant_permutation_tb;
    import kf800_pkg::*;

    localparam int   TAIL_CYCLES = 60;
    localparam t_lane IOTA_RC [22] = '{
        32'h0000_0001, 32'h0000_8082, 32'h0000_808a, 32'h8000_8000,
        32'h0000_808b, 32'h8000_0001, 32'h8000_8081, 32'h0000_8009,
        32'h0000_008a, 32'h0000_0088, 32'h8000_8009, 32'h8000_000a,
        32'h8000_808b, 32'h0000_008b, 32'h0000_8089, 32'h0000_8003,
        32'h0000_8002, 32'h0000_0080, 32'h0000_800a, 32'h8000_000a,
        32'h8000_8081, 32'h0000_8080
    };

    typedef struct {
        t_lane            lane;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_lane_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_start;
    logic [31:0]      i_lane_in;
    logic             o_busy;
    logic             o_valid;
    logic [31:0]      o_lane_out;
    logic [IDX_W-1:0] o_lane_index;
    logic             o_last_lane;

    t_lane        perm_state [LANES];
    int           lanes_loaded;
    t_lane_result expected_lanes [$];
    int           mismatch_count;

    keccak_f800_variant_permutation uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_lane_in    (i_lane_in),
        .o_busy       (o_busy),
        .o_valid      (o_valid),
        .o_lane_out   (o_lane_out),
        .o_lane_index (o_lane_index),
        .o_last_lane  (o_last_lane)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_lane rol32(input t_lane x, input int n);
        int m;
        m = n % 32;
        return (x << m) | (x >> ((32 - m) % 32));
    endfunction

    function automatic void apply_rounds();
        t_lane s [LANES];
        t_lane col [5];
        t_lane d [5];
        t_lane row [5];
        s = perm_state;
        for (int r = 0; r < ROUND_COUNT; r++) begin
            for (int i = 0; i < 5; i++)
                col[i] = s[i] ^ s[i+5] ^ s[i+10] ^ s[i+15] ^ s[i+20];
            for (int i = 0; i < 5; i++)
                d[i] = col[(i+4)%5] ^ rol32(col[(i+1)%5], 1);
            for (int i = 0; i < LANES; i++)
                s[i] = s[i] ^ d[i%5];
            for (int k = LANES - 1; k >= 2; k--)
                s[k] = rol32(s[k-1], ((k * (k + 1)) / 2) % 32);
            s[1] = rol32(s[1], 1);
            for (int b = 0; b < LANES; b += 5) begin
                for (int i = 0; i < 5; i++)
                    row[i] = s[b+i];
                for (int i = 0; i < 5; i++)
                    s[b+i] = row[i] ^ (~row[(i+1)%5] & row[(i+2)%5]);
            end
            s[0] = s[0] ^ IOTA_RC[r];
        end
        perm_state = s;
    endfunction

    function automatic void record_lane(input t_lane value);
        t_lane_result res;
        perm_state[lanes_loaded] = value;
        lanes_loaded++;
        if (lanes_loaded == LANES) begin
            apply_rounds();
            for (int k = 0; k < LANES; k++) begin
                res.lane  = perm_state[k];
                res.index = IDX_W'(k);
                res.last  = (k == LANES - 1);
                expected_lanes.push_back(res);
            end
            lanes_loaded = 0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_lane random_lane();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return t_lane'(1) << $urandom_range(0, 31);
            3:       return ~(t_lane'(1) << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic load_lane(input t_lane value, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0) begin
            i_start   <= 1'b0;
            i_lane_in <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        i_start   <= 1'b1;
        i_lane_in <= value;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        record_lane(value);
    endtask

    task automatic test_directed_extremes();
        t_lane v;
        for (int k = 0; k < LANES; k++) begin
            case (k % 6)
                0: v = '0;
                1: v = '1;
                2: v = t_lane'(1) << k;
                3: v = 32'h8000_0000 >> k;
                4: v = 32'h5555_5555;
                default: v = 32'haaaa_aaaa;
            endcase
            load_lane(v, k < 12);
        end
    endtask

    task automatic test_random_runs(input int runs);
        bit quiet;
        for (int r = 0; r < runs; r++) begin
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < LANES; k++)
                load_lane(random_lane(), quiet);
        end
    endtask

    task automatic test_streaming_runs(input int runs);
        for (int r = 0; r < runs; r++)
            for (int k = 0; k < LANES; k++)
                load_lane($urandom(), 1'b1);
    endtask

    task automatic test_sparse_runs(input int runs);
        t_lane v;
        for (int r = 0; r < runs; r++) begin
            for (int k = 0; k < LANES; k++) begin
                v = '0;
                if (r > 0 && $urandom_range(0, 7) == 0)
                    v = t_lane'(1) << $urandom_range(0, 31);
                load_lane(v, 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_lanes
        t_lane_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (expected_lanes.size() == 0) begin
                report_mismatch($sformatf("unexpected lane %0d value %h",
                                          o_lane_index, o_lane_out));
            end else begin
                want = expected_lanes.pop_front();
                if (o_lane_out !== want.lane)
                    report_mismatch($sformatf("lane %0d value %h, want %h",
                                              want.index, o_lane_out, want.lane));
                if (o_lane_index !== want.index)
                    report_mismatch($sformatf("lane index %0d, want %0d",
                                              o_lane_index, want.index));
                if (o_last_lane !== want.last)
                    report_mismatch($sformatf("last flag %b on lane %0d, want %b",
                                              o_last_lane, want.index, want.last));
            end
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_lane_in      = '0;
        lanes_loaded   = 0;
        mismatch_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_random_runs(6);
        test_streaming_runs(2);
        test_sparse_runs(2);

        i_start <= 1'b0;
        while (expected_lanes.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_lanes.size() == 0) begin
            $display("keccak_f800_variant_permutation_tb passed");
        end else begin
            $display("keccak_f800_variant_permutation_tb failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("keccak_f800_variant_permutation_tb failed");
        $finish;
    end

endmodule

FILE: sim.f
src/kf800_pkg.sv
src/kf800_ctrl.sv
src/kf800_dp.sv
src/keccak_f800_variant_permutation.sv
src/kf800_checker.sv
dv/keccak_f800_variant_permutation_tb.sv
